FILE: rtl/svs_pkg.sv
package svs_pkg;

   // Sizing of the stores
   localparam int KEY_SLOTS   = 64;
   localparam int VALUE_DEPTH = 256;
   localparam int MAX_SHADOWS = 4;
   localparam int SCOPE_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;

   // Fixed field widths
   localparam int OP_W     = 3;
   localparam int KEY_W    = 64;
   localparam int NEWVAL_W = 32;
   localparam int RDVAL_W  = 32;
   localparam int STATUS_W = 3;

   // Derived widths
   localparam int SLOT_W   = $clog2(KEY_SLOTS);
   localparam int SCAN_W   = $clog2(KEY_SLOTS + 1);
   localparam int CNT_W    = $clog2(MAX_SHADOWS + 1);
   localparam int POS_AW   = $clog2(KEY_SLOTS * MAX_SHADOWS);
   localparam int VAL_AW   = $clog2(VALUE_DEPTH);
   localparam int TOP_W    = $clog2(VALUE_DEPTH + 1);
   localparam int SCOPE_AW = $clog2(SCOPE_DEPTH);
   localparam int SCOPE_W  = $clog2(SCOPE_DEPTH + 1);

   // Operation codes
   localparam logic [OP_W-1:0] OP_SET  = 3'd0;
   localparam logic [OP_W-1:0] OP_LET  = 3'd1;
   localparam logic [OP_W-1:0] OP_GET  = 3'd2;
   localparam logic [OP_W-1:0] OP_PUSH = 3'd3;
   localparam logic [OP_W-1:0] OP_POP  = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_KEYS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SHADOW_LIMIT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_VALUES_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SCOPES_FULL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW    = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_CNT,
      S_POS,
      S_DECIDE,
      S_VAL,
      S_PUSH,
      S_POP_CHK,
      S_POP_OWN,
      S_POP_CNT,
      S_POP_UPD,
      S_RESP
   } state_type;

   typedef struct packed {
      logic take;
      logic scan;
      logic commit;
      logic load_val;
      logic push;
      logic pop_err;
      logic pop_sel;
      logic pop_upd;
      logic pop_finish;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic            scan_done;
      logic            get_hit;
      logic            pop_more;
      logic            scope_base;
      logic            rsp_free;
      logic [OP_W-1:0] op;
   } stat_type;

endpackage

FILE: rtl/svs_ctrl.sv
module svs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  svs_pkg::stat_type stat,
   output svs_pkg::cmd_type  cmd
);
   import svs_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (stat.op == OP_SET || stat.op == OP_LET || stat.op == OP_GET) begin
                  state_in = S_SCAN;
               end else if (stat.op == OP_PUSH) begin
                  state_in = S_PUSH;
               end else if (stat.op == OP_POP) begin
                  state_in = S_POP_CHK;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_CNT;
            end
         end
         S_CNT:    state_in = S_POS;
         S_POS:    state_in = S_DECIDE;
         S_DECIDE: begin
            if (stat.op == OP_GET && stat.get_hit) begin
               state_in = S_VAL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_VAL:    state_in = S_RESP;
         S_PUSH:   state_in = S_RESP;
         S_POP_CHK: begin
            if (stat.scope_base) begin
               state_in = S_RESP;
            end else begin
               state_in = S_POP_OWN;
            end
         end
         S_POP_OWN: begin
            if (stat.pop_more) begin
               state_in = S_POP_CNT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_POP_CNT: state_in = S_POP_UPD;
         S_POP_UPD: state_in = S_POP_OWN;
         S_RESP: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         S_SCAN:   cmd.scan = 1'b1;
         S_DECIDE: cmd.commit = (stat.op == OP_SET || stat.op == OP_LET);
         S_VAL:    cmd.load_val = 1'b1;
         S_PUSH:   cmd.push = 1'b1;
         S_POP_CHK: cmd.pop_err = stat.scope_base;
         S_POP_OWN: cmd.pop_finish = !stat.pop_more;
         S_POP_CNT: cmd.pop_sel = 1'b1;
         S_POP_UPD: cmd.pop_upd = 1'b1;
         S_RESP:   cmd.load_rsp = stat.rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/svs_dp.sv
module svs_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [svs_pkg::OP_W-1:0]         req_operation,
   input  logic [svs_pkg::KEY_W-1:0]        req_key,
   input  logic [svs_pkg::NEWVAL_W-1:0]     req_new_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [svs_pkg::RDVAL_W-1:0]      rsp_read_value,
   output logic                             rsp_found,
   output logic [svs_pkg::STATUS_W-1:0]     rsp_status,
   input  svs_pkg::cmd_type                 cmd,
   output svs_pkg::stat_type                stat
);
   import svs_pkg::*;

   // Stores
   logic [KEY_W-1:0]       key_mem   [KEY_SLOTS];
   logic [CNT_W-1:0]       cnt_mem   [KEY_SLOTS];
   logic [VAL_AW-1:0]      pos_mem   [KEY_SLOTS*MAX_SHADOWS];
   logic [VALUE_WIDTH-1:0] value_mem [VALUE_DEPTH];
   logic [SLOT_W-1:0]      owner_mem [VALUE_DEPTH];
   logic [TOP_W-1:0]       scope_begin_ff [SCOPE_DEPTH];

   logic [KEY_SLOTS-1:0]   valid_ff;
   logic [TOP_W-1:0]       top_ff;
   logic [SCOPE_W-1:0]     scope_top_ff;

   // Latched request
   logic [OP_W-1:0]        op_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;

   // Scan pipeline
   logic [SCAN_W-1:0]      scan_ff;
   logic                   cmp_vld_ff;
   logic [SLOT_W-1:0]      cmp_idx_ff;
   logic [KEY_W-1:0]       key_rd_ff;
   logic                   hit_ff;
   logic                   free_ok_ff;
   logic [SLOT_W-1:0]      slot_ff;

   // Read data
   logic [CNT_W-1:0]       cnt_rd_ff;
   logic                   cnt_vld_ff;
   logic [VAL_AW-1:0]      pos_rd_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;
   logic [SLOT_W-1:0]      owner_rd_ff;

   // Result
   logic [RDVAL_W-1:0]     res_value_ff;
   logic                   res_found_ff;
   logic [STATUS_W-1:0]    res_status_ff;
   logic                   rsp_valid_ff;
   logic [RDVAL_W-1:0]     rsp_value_ff;
   logic                   rsp_found_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic                   match;
   logic [CNT_W-1:0]       n;
   logic [CNT_W-1:0]       n_dec;
   logic [TOP_W-1:0]       mark;
   logic [SLOT_W-1:0]      cnt_addr;
   logic [POS_AW-1:0]      pos_base;
   logic [POS_AW-1:0]      pos_rd_addr;
   logic [POS_AW-1:0]      pos_wr_addr;
   logic                   hitc;
   logic                   ovw;
   logic                   create;
   logic [STATUS_W-1:0]    commit_st;

   // Decode
   assign match    = cmp_vld_ff && valid_ff[cmp_idx_ff] && (key_rd_ff == key_ff);
   assign n        = cnt_vld_ff ? cnt_rd_ff : '0;
   assign n_dec    = (n != '0) ? n - CNT_W'(1) : '0;
   assign mark     = scope_begin_ff[SCOPE_AW'(scope_top_ff - SCOPE_W'(1))];
   assign cnt_addr = cmd.pop_sel ? owner_rd_ff : slot_ff;
   assign pos_base = POS_AW'(slot_ff) * POS_AW'(MAX_SHADOWS);
   assign pos_rd_addr = pos_base + POS_AW'(n) - POS_AW'(1);
   assign pos_wr_addr = pos_base + POS_AW'(n);
   assign hitc     = hit_ff && (n != '0);

   // Pick overwrite, error or new instance
   always_comb begin
      ovw       = 1'b0;
      create    = 1'b0;
      commit_st = ST_OK;
      if (hitc && (op_ff == OP_SET || TOP_W'(pos_rd_ff) >= mark)) begin
         ovw = 1'b1;
      end else if (hitc && n >= CNT_W'(MAX_SHADOWS)) begin
         commit_st = ST_SHADOW_LIMIT;
      end else if (!hit_ff && !free_ok_ff) begin
         commit_st = ST_KEYS_FULL;
      end else if (top_ff >= TOP_W'(VALUE_DEPTH)) begin
         commit_st = ST_VALUES_FULL;
      end else begin
         create = 1'b1;
      end
   end

   // Free-running memory reads
   always_ff @(posedge clock) begin
      key_rd_ff   <= key_mem[scan_ff[SLOT_W-1:0]];
      cnt_rd_ff   <= cnt_mem[cnt_addr];
      pos_rd_ff   <= pos_mem[pos_rd_addr];
      val_rd_ff   <= value_mem[pos_rd_ff];
      owner_rd_ff <= owner_mem[VAL_AW'(top_ff - TOP_W'(1))];
      cnt_vld_ff  <= valid_ff[cnt_addr];
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (cmd.commit && ovw) begin
         value_mem[pos_rd_ff] <= val_ff;
      end else if (cmd.commit && create) begin
         value_mem[top_ff[VAL_AW-1:0]] <= val_ff;
      end
      if (cmd.commit && create) begin
         owner_mem[top_ff[VAL_AW-1:0]] <= slot_ff;
         pos_mem[pos_wr_addr]          <= top_ff[VAL_AW-1:0];
         key_mem[slot_ff]              <= key_ff;
      end
      if (cmd.commit && create) begin
         cnt_mem[slot_ff] <= n + CNT_W'(1);
      end else if (cmd.pop_upd) begin
         cnt_mem[owner_rd_ff] <= n_dec;
      end
   end

   // Request latch and scan
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         val_ff <= VALUE_WIDTH'(req_new_value);
      end
      if (cmd.scan && !hit_ff && match) begin
         slot_ff <= cmp_idx_ff;
      end else if (cmd.scan && !hit_ff && cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_ok_ff) begin
         slot_ff <= cmp_idx_ff;
      end
      cmp_idx_ff <= scan_ff[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if (cmd.take) begin
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ok_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan && (scan_ff < SCAN_W'(KEY_SLOTS));
         if (cmd.scan && (scan_ff < SCAN_W'(KEY_SLOTS))) begin
            scan_ff <= scan_ff + SCAN_W'(1);
         end
         if (cmd.scan && match) begin
            hit_ff <= 1'b1;
         end
         if (cmd.scan && !hit_ff && cmp_vld_ff && !valid_ff[cmp_idx_ff]) begin
            free_ok_ff <= 1'b1;
         end
      end
   end

   // Table state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         top_ff       <= '0;
         scope_top_ff <= SCOPE_W'(1);
      end else begin
         if (cmd.commit && create) begin
            valid_ff[slot_ff] <= 1'b1;
            top_ff            <= top_ff + TOP_W'(1);
         end
         if (cmd.pop_upd) begin
            if (n_dec == '0) begin
               valid_ff[owner_rd_ff] <= 1'b0;
            end
            top_ff <= top_ff - TOP_W'(1);
         end
         if (cmd.push && scope_top_ff < SCOPE_W'(SCOPE_DEPTH)) begin
            scope_top_ff <= scope_top_ff + SCOPE_W'(1);
         end
         if (cmd.pop_finish) begin
            scope_top_ff <= scope_top_ff - SCOPE_W'(1);
         end
      end
   end

   // Scope marks; base entry is zero from reset
   always_ff @(posedge clock) begin
      if (reset) begin
         scope_begin_ff[0] <= '0;
      end else if (cmd.push && scope_top_ff < SCOPE_W'(SCOPE_DEPTH)) begin
         scope_begin_ff[scope_top_ff[SCOPE_AW-1:0]] <= top_ff;
      end
   end

   // Result fields
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         res_value_ff  <= '0;
         res_found_ff  <= 1'b0;
         res_status_ff <= ST_OK;
      end else begin
         if (cmd.commit) begin
            res_status_ff <= commit_st;
         end
         if (cmd.load_val) begin
            res_value_ff <= RDVAL_W'(val_rd_ff);
            res_found_ff <= 1'b1;
         end
         if (cmd.push && scope_top_ff >= SCOPE_W'(SCOPE_DEPTH)) begin
            res_status_ff <= ST_SCOPES_FULL;
         end
         if (cmd.pop_err) begin
            res_status_ff <= ST_UNDERFLOW;
         end
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_value_ff  <= res_value_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;

   // Status to controller
   always_comb begin
      stat.scan_done  = cmp_vld_ff && (match || cmp_idx_ff == SLOT_W'(KEY_SLOTS - 1));
      stat.get_hit    = hitc;
      stat.pop_more   = top_ff > mark;
      stat.scope_base = scope_top_ff <= SCOPE_W'(1);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
      stat.op         = cmd.take ? req_operation : op_ff;
   end

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(VALUE_DEPTH))
      else $error("value stack above depth");

   a_scope_bound: assert property (@(posedge clock) disable iff (reset)
      scope_top_ff >= SCOPE_W'(1) && scope_top_ff <= SCOPE_W'(SCOPE_DEPTH))
      else $error("scope count out of range");

   a_pop_step: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_upd |-> top_ff > mark)
      else $error("pop removed below scope mark");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");

   a_create_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && create) |=> top_ff == $past(top_ff) + TOP_W'(1))
      else $error("new instance did not advance stack");

endmodule

FILE: rtl/scoped_variable_store.sv
// Scoped variable table with shadowing.
// Input channel req_*: one word per operation (set, let, get, push scope,
// pop scope) with a key and a new value. Result channel rsp_*: exactly one
// word per operation with read_value, found and status.
// Set, let and get compare the key against the slot key memory one slot per
// cycle and stop at the slot that holds the key. Pop scope makes one pass
// through owner and count memories per removed value; a pop of the base
// scope reports underflow. Other codes go straight to the result. One
// operation is in flight at a time; the next word is taken as soon as the
// result is parked in the output register. Reset empties the table and opens
// the base scope; no clearing pass is needed.
// If the receiver stalls, the result stays in the output register and the
// block finishes at most one more operation, then holds until it drains.
module scoped_variable_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [svs_pkg::OP_W-1:0]     req_operation,
   input  logic [svs_pkg::KEY_W-1:0]    req_key,
   input  logic [svs_pkg::NEWVAL_W-1:0] req_new_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [svs_pkg::RDVAL_W-1:0]  rsp_read_value,
   output logic                         rsp_found,
   output logic [svs_pkg::STATUS_W-1:0] rsp_status
);
   import svs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   svs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   svs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

FILE: tb/sv/svs_checker.sv
`timescale 1ns / 1ps

module svs_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [svs_pkg::OP_W-1:0]     req_operation,
   input  logic [svs_pkg::KEY_W-1:0]    req_key,
   input  logic [svs_pkg::NEWVAL_W-1:0] req_new_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [svs_pkg::RDVAL_W-1:0]  rsp_read_value,
   input  logic                         rsp_found,
   input  logic [svs_pkg::STATUS_W-1:0] rsp_status,
   output int                           fail_count,
   output int                           pending_count
);
   import svs_pkg::*;

   typedef struct packed {
      logic [RDVAL_W-1:0]  read_value;
      logic                found;
      logic [STATUS_W-1:0] status;
   } answer_type;

   // shadow copy of the table
   logic [KEY_W-1:0]       tbl_key [KEY_SLOTS];
   logic                   tbl_live [KEY_SLOTS];
   int                     tbl_count [KEY_SLOTS];
   int                     tbl_pos [KEY_SLOTS][MAX_SHADOWS];
   logic [VALUE_WIDTH-1:0] stk_word [VALUE_DEPTH];
   int                     stk_owner [VALUE_DEPTH];
   int                     stk_top;
   int                     mark [SCOPE_DEPTH];
   int                     open_scopes;

   answer_type answer_q[$];

   assign pending_count = answer_q.size();

   function automatic int lookup(input logic [KEY_W-1:0] k);
      for (int s = 0; s < KEY_SLOTS; s++)
         if (tbl_live[s] && tbl_key[s] == k) return s;
      return -1;
   endfunction

   function automatic int inner(input int s);
      return tbl_pos[s][tbl_count[s]-1];
   endfunction

   // write path for set and let
   function automatic logic [STATUS_W-1:0] write_key(input logic [KEY_W-1:0] k,
         input logic [VALUE_WIDTH-1:0] v, input logic scoped);
      int s;
      logic overwrite;
      s = lookup(k);
      if (s >= 0) begin
         overwrite = tbl_count[s] > 0;
         if (scoped && overwrite) overwrite = inner(s) >= mark[open_scopes-1];
         if (overwrite) begin
            stk_word[inner(s)] = v;
            return ST_OK;
         end
         if (tbl_count[s] >= MAX_SHADOWS) return ST_SHADOW_LIMIT;
         if (stk_top >= VALUE_DEPTH) return ST_VALUES_FULL;
      end else begin
         s = -1;
         for (int i = KEY_SLOTS - 1; i >= 0; i--)
            if (!tbl_live[i]) s = i;
         if (s < 0) return ST_KEYS_FULL;
         if (stk_top >= VALUE_DEPTH) return ST_VALUES_FULL;
         tbl_live[s] = 1'b1;
         tbl_key[s] = k;
         tbl_count[s] = 0;
      end
      stk_word[stk_top] = v;
      stk_owner[stk_top] = s;
      tbl_pos[s][tbl_count[s]] = stk_top;
      tbl_count[s]++;
      stk_top++;
      return ST_OK;
   endfunction

   function automatic answer_type predict_answer(input logic [OP_W-1:0] op,
         input logic [KEY_W-1:0] k, input logic [NEWVAL_W-1:0] v);
      answer_type a;
      int s;
      int o;
      a = '0;
      case (op)
         OP_SET: a.status = write_key(k, v[VALUE_WIDTH-1:0], 1'b0);
         OP_LET: a.status = write_key(k, v[VALUE_WIDTH-1:0], 1'b1);
         OP_GET: begin
            s = lookup(k);
            if (s >= 0 && tbl_count[s] > 0) begin
               a.read_value = stk_word[inner(s)];
               a.found = 1'b1;
            end
         end
         OP_PUSH: begin
            if (open_scopes >= SCOPE_DEPTH) a.status = ST_SCOPES_FULL;
            else begin
               mark[open_scopes] = stk_top;
               open_scopes++;
            end
         end
         OP_POP: begin
            if (open_scopes <= 1) a.status = ST_UNDERFLOW;
            else begin
               while (stk_top > mark[open_scopes-1]) begin
                  o = stk_owner[stk_top-1];
                  if (tbl_count[o] > 0) tbl_count[o]--;
                  if (tbl_count[o] == 0) tbl_live[o] = 1'b0;
                  stk_top--;
               end
               open_scopes--;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      stk_top = 0;
      open_scopes = 1;
      mark[0] = 0;
      for (int s = 0; s < KEY_SLOTS; s++) begin
         tbl_live[s] = 1'b0;
         tbl_count[s] = 0;
      end
   end

   // predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) report("unexpected word", rsp_status, 0);
            else begin
               want = answer_q.pop_front();
               if (rsp_read_value !== want.read_value)
                  report("read_value", rsp_read_value, want.read_value);
               if (rsp_found !== want.found) report("found", rsp_found, want.found);
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready)
            answer_q.push_back(predict_answer(req_operation, req_key, req_new_value));
      end
   end
endmodule

FILE: tb/sv/tb_scoped_variable_store.sv
`timescale 1ns / 1ps

module tb_scoped_variable_store;
   import svs_pkg::*;

   localparam int RANDOM_WORDS = 390;
   localparam int STALL_LIMIT  = 20000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic [NEWVAL_W-1:0] req_new_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [RDVAL_W-1:0]  rsp_read_value;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   int                  fail_count;
   int                  pending_count;
   logic                quiet = 1'b0;
   logic                hold_rsp = 1'b0;
   int                  idle_cycles = 0;
   logic [KEY_W-1:0]    key_pool [12];

   always #10 clock = ~clock;

   scoped_variable_store DUT (.*);

   svs_checker u_checker (.*);

   // receiver: random stalls, one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         if (!quiet && $urandom_range(3) == 0) begin
            n = $urandom_range(6, 1);
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
         input logic [NEWVAL_W-1:0] v);
      req_operation <= op;
      req_key <= k;
      req_new_value <= v;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (!quiet && $urandom_range(4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] wide_key();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int op;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < 12; i++) key_pool[i] = wide_key();

      // directed: extremes, every operation, underflow and shadow limit
      send_word(OP_POP, '0, '0);
      send_word(OP_GET, '1, '0);
      send_word(OP_SET, '1, '1);
      send_word(OP_GET, '1, '0);
      send_word(OP_SET, '0, '0);
      send_word(OP_LET, '0, 32'h5a5a_a5a5);
      send_word(OP_PUSH, '0, '0);
      send_word(OP_LET, '1, 32'h1234_5678);
      send_word(OP_LET, '1, 32'h0000_0001);
      send_word(OP_SET, '0, 32'hdead_beef);
      send_word(OP_GET, '1, '0);
      for (int i = 0; i < 4; i++) begin
         send_word(OP_PUSH, '0, '0);
         send_word(OP_LET, '1, i);
      end
      send_word(OP_GET, '1, '0);
      send_word(3'd5, '1, '1);
      send_word(3'd7, '0, '1);
      for (int i = 0; i < 6; i++) send_word(OP_POP, '0, '0);
      send_word(OP_GET, '1, '0);
      drain();

      // scope stack full, then empty again
      for (int i = 0; i < 17; i++) send_word(OP_PUSH, '0, '0);
      for (int i = 0; i < 16; i++) send_word(OP_POP, '0, '0);
      // key table full
      send_word(OP_PUSH, '0, '0);
      for (int i = 0; i < 66; i++) send_word(OP_SET, 64'h100 + i, i);
      send_word(OP_POP, '0, '0);
      // value store full: every slot shadowed up to 4 times
      for (int d = 0; d < 4; d++) begin
         send_word(OP_PUSH, '0, '0);
         send_word(OP_LET, '0, d);
         send_word(OP_LET, '1, d);
         for (int i = 0; i < 64; i++) send_word(OP_LET, 64'h200 + i, $urandom);
      end
      send_word(OP_PUSH, '0, '0);
      send_word(OP_LET, 64'h200, 1);
      send_word(OP_SET, 64'h999, 1);
      send_word(OP_GET, 64'h23f, 0);
      drain();
      for (int i = 0; i < 5; i++) send_word(OP_POP, '0, '0);

      // long receiver hold-off while words keep arriving
      hold_rsp = 1'b1;
      for (int i = 0; i < 8; i++) send_word(OP_GET, key_pool[i], '0);
      drain();

      // random mix over a small key pool with occasional wide keys
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i > RANDOM_WORDS - 100) quiet = 1'b1;
         op = $urandom_range(99);
         if (op < 25) send_word(OP_SET, key_pool[$urandom_range(11)], $urandom);
         else if (op < 50) send_word(OP_LET, key_pool[$urandom_range(11)], $urandom);
         else if (op < 72) send_word(OP_GET, key_pool[$urandom_range(11)], $urandom);
         else if (op < 83) send_word(OP_PUSH, wide_key(), $urandom);
         else if (op < 94) send_word(OP_POP, wide_key(), $urandom);
         else if (op < 97) send_word(OP_GET, wide_key(), $urandom);
         else send_word($urandom_range(7, 5), wide_key(), $urandom);
      end
      drain();
      repeat (100) @(negedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
